// File: rtl/core/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared widths, issuer class codes and helper functions for the card number
// checker: prefix classification, doubled-digit table, multiple-of-ten test.
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int CARD_W         = 60;
    localparam int DIG_W          = 4;
    localparam int SUM_W          = 8;
    localparam int NUM_DIGITS_DEF = 18;

    // binary to bcd conversion is split into equal slices of input bits
    localparam int BITS_PER_STAGE = 8;
    localparam int DABBLE_STAGES  = (CARD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_W          = DABBLE_STAGES * BITS_PER_STAGE;

    // issuer classes
    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_P4      = 2'd1,
        KIND_P34_37  = 2'd2,
        KIND_P51_55  = 2'd3
    } card_kind_t;

    // inclusive number ranges of the issuer classes
    localparam logic [CARD_W-1:0] P4_13_LO  = 60'd4000000000000;
    localparam logic [CARD_W-1:0] P4_13_HI  = 60'd4999999999999;
    localparam logic [CARD_W-1:0] P4_16_LO  = 60'd4000000000000000;
    localparam logic [CARD_W-1:0] P4_16_HI  = 60'd4999999999999999;
    localparam logic [CARD_W-1:0] P34_LO    = 60'd340000000000000;
    localparam logic [CARD_W-1:0] P34_HI    = 60'd349999999999999;
    localparam logic [CARD_W-1:0] P37_LO    = 60'd370000000000000;
    localparam logic [CARD_W-1:0] P37_HI    = 60'd379999999999999;
    localparam logic [CARD_W-1:0] P51_55_LO = 60'd5100000000000000;
    localparam logic [CARD_W-1:0] P51_55_HI = 60'd5599999999999999;

    // issuer class from length and leading digits
    function automatic card_kind_t classify(input logic [CARD_W-1:0] v);
        card_kind_t k;
        if ((v >= P4_13_LO && v <= P4_13_HI) || (v >= P4_16_LO && v <= P4_16_HI))
        begin
            k = KIND_P4;
        end
        else if ((v >= P34_LO && v <= P34_HI) || (v >= P37_LO && v <= P37_HI))
        begin
            k = KIND_P34_37;
        end
        else if (v >= P51_55_LO && v <= P51_55_HI)
        begin
            k = KIND_P51_55;
        end
        else
        begin
            k = KIND_INVALID;
        end
        return k;
    endfunction

    // doubled digit with its two decimal digits folded together
    function automatic logic [DIG_W-1:0] luhn_double(input logic [DIG_W-1:0] d);
        logic [DIG_W-1:0] r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // true when the sum is a multiple of ten
    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * 10 < (1 << SUM_W); k++)
        begin
            if (s == SUM_W'(k * 10))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// File: rtl/core/clc_prefix_stage.sv
// ----------------------------------------------------------------------------
// clc_prefix_stage
// Input register of the pipeline: captures the card number and its issuer
// class, and hands the number on zero-padded for the bcd conversion.
// ----------------------------------------------------------------------------
module clc_prefix_stage
    import clc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CARD_W-1:0] in_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PAD_W-1:0]  out_bin,
    output card_kind_t        out_kind
);

    logic              valid_reg;
    logic [CARD_W-1:0] number_reg;
    card_kind_t        kind_reg;
    logic              load;

    // stage takes a request when empty or when its content moves on
    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload with classification
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            number_reg <= in_number;
            kind_reg   <= classify(in_number);
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = {{(PAD_W - CARD_W){1'b0}}, number_reg};
    assign out_kind  = kind_reg;

endmodule

// File: rtl/core/clc_dabble_stage.sv
// ----------------------------------------------------------------------------
// clc_dabble_stage
// One slice of the shift-and-add-3 binary to bcd conversion: takes a fixed
// number of input bits, msb first, into a bcd register of NUM_DIGITS digits.
// Carries out of the top digit are dropped, keeping the low digits only.
// ----------------------------------------------------------------------------
module clc_dabble_stage
    import clc_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [PAD_W-1:0]            in_bin,
    input  logic [NUM_DIGITS*DIG_W-1:0] in_bcd,
    input  card_kind_t                  in_kind,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [PAD_W-1:0]            out_bin,
    output logic [NUM_DIGITS*DIG_W-1:0] out_bcd,
    output card_kind_t                  out_kind
);

    localparam int BCD_W = NUM_DIGITS * DIG_W;

    logic             valid_reg;
    logic [PAD_W-1:0] bin_reg;
    logic [PAD_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    card_kind_t       kind_reg;
    logic             load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // correct digits of five and above, then shift in the next bit
    always_comb
    begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int j = 0; j < BITS_PER_STAGE; j++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_next[d*DIG_W +: DIG_W] >= 4'd5)
                begin
                    bcd_next[d*DIG_W +: DIG_W] = bcd_next[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[PAD_W-1]};
            bin_next = {bin_next[PAD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            bin_reg  <= bin_next;
            bcd_reg  <= bcd_next;
            kind_reg <= in_kind;
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;
    assign out_kind  = kind_reg;

endmodule

// File: rtl/core/clc_luhn_sum.sv
// ----------------------------------------------------------------------------
// clc_luhn_sum
// Luhn digit sum over the decimal digits in two register stages: doubled
// digit mapping and group sums first, then the total, the modulo ten test
// and the final class, which also form the output register.
// ----------------------------------------------------------------------------
module clc_luhn_sum
    import clc_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [NUM_DIGITS*DIG_W-1:0] in_bcd,
    input  card_kind_t                  in_kind,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  card_kind,
    output logic                        luhn_ok,
    output logic [SUM_W-1:0]            luhn_sum
);

    localparam int GROUP_DIGITS = 4;
    localparam int GROUPS       = (NUM_DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
    localparam int GRP_W        = 6;

    logic             a_valid_reg;
    logic [GRP_W-1:0] grp_reg [GROUPS];
    logic [GRP_W-1:0] grp_next [GROUPS];
    card_kind_t       a_kind_reg;
    logic             a_load;

    logic             b_valid_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             ok_reg;
    logic             ok_next;
    card_kind_t       kind_reg;
    logic             b_load;

    assign b_load   = !b_valid_reg || !out_stall;
    assign a_load   = !a_valid_reg || b_load;
    assign in_ready = a_load;

    // digit weighting: every second digit from the right, starting with the second, is doubled
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
        end
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (d % 2 == 1)
            begin
                grp_next[d / GROUP_DIGITS] = grp_next[d / GROUP_DIGITS]
                    + GRP_W'(luhn_double(in_bcd[d*DIG_W +: DIG_W]));
            end
            else
            begin
                grp_next[d / GROUP_DIGITS] = grp_next[d / GROUP_DIGITS]
                    + GRP_W'(in_bcd[d*DIG_W +: DIG_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && in_valid)
        begin
            grp_reg    <= grp_next;
            a_kind_reg <= in_kind;
        end
    end

    // total and modulo ten test
    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            sum_next = sum_next + SUM_W'(grp_reg[g]);
        end
        ok_next = is_mult10(sum_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // output register, class forced invalid on a failed check
    always_ff @(posedge clk)
    begin
        if (b_load && a_valid_reg)
        begin
            sum_reg  <= sum_next;
            ok_reg   <= ok_next;
            kind_reg <= ok_next ? a_kind_reg : KIND_INVALID;
        end
    end

    assign out_valid = b_valid_reg;
    assign card_kind = kind_reg;
    assign luhn_ok   = ok_reg;
    assign luhn_sum  = sum_reg;

endmodule

// File: rtl/core/card_number_luhn_classifier.sv
// path from an accepted request to its result on the output:
// 1 input/classification stage, 8 bcd conversion stages of 8 bits each,
// 2 digit sum stages; throughput one request per cycle while the output is not stalled
// every stage holds its content while the next is full, bubbles close up
// reset clears the valid bits only; no configuration, no stored state
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// Luhn mod 10 check of a binary card number with issuer prefix classification.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier
    import clc_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CARD_W-1:0] card_number,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        card_kind,
    output logic              luhn_ok,
    output logic [SUM_W-1:0]  luhn_sum
);

    localparam int BCD_W = NUM_DIGITS * DIG_W;

    logic             pre_ready;
    logic             stg_valid [DABBLE_STAGES+1];
    logic             stg_ready [DABBLE_STAGES+1];
    logic [PAD_W-1:0] stg_bin   [DABBLE_STAGES+1];
    logic [BCD_W-1:0] stg_bcd   [DABBLE_STAGES+1];
    card_kind_t       stg_kind  [DABBLE_STAGES+1];

    assign in_stall = !pre_ready;

    // input register and prefix classification
    clc_prefix_stage u_prefix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (pre_ready),
        .in_number (card_number),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_bin   (stg_bin[0]),
        .out_kind  (stg_kind[0])
    );

    assign stg_bcd[0] = '0;

    // binary to bcd conversion chain
    for (genvar s = 0; s < DABBLE_STAGES; s++)
    begin : g_dabble
        clc_dabble_stage #(
            .NUM_DIGITS (NUM_DIGITS)
        ) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_ready  (stg_ready[s]),
            .in_bin    (stg_bin[s]),
            .in_bcd    (stg_bcd[s]),
            .in_kind   (stg_kind[s]),
            .out_valid (stg_valid[s+1]),
            .out_ready (stg_ready[s+1]),
            .out_bin   (stg_bin[s+1]),
            .out_bcd   (stg_bcd[s+1]),
            .out_kind  (stg_kind[s+1])
        );
    end

    // digit sum, check and output register
    clc_luhn_sum #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_luhn
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[DABBLE_STAGES]),
        .in_ready  (stg_ready[DABBLE_STAGES]),
        .in_bcd    (stg_bcd[DABBLE_STAGES]),
        .in_kind   (stg_kind[DABBLE_STAGES]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .card_kind (card_kind),
        .luhn_ok   (luhn_ok),
        .luhn_sum  (luhn_sum)
    );

    // a valid issuer class only comes with a passed check
    a_kind_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && card_kind != KIND_INVALID |-> luhn_ok)
        else $error("issuer class given on a failed check");

    // digit sum bounded by nine per digit
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> luhn_sum <= SUM_W'(NUM_DIGITS * 9))
        else $error("digit sum out of range");

    // input only held back when the whole pipeline is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

endmodule
